[design/spq_pkg.sv]
// Shared constants and control types for the sorted priority queue.
`default_nettype none

package spq_pkg;

	// Default sizes
	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 8;

	// Fixed field widths
	localparam int DATA_W   = 8;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;

	// Operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;   // insert new entry this cycle
		logic deq;   // remove head this cycle
	} spq_ctrl_t;

endpackage

`default_nettype wire

[design/spq_cell.sv]
// One slot of the sorted chain: holds a data byte and a key, trades with neighbors.
`default_nettype none

module spq_cell
	import spq_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire                     clk,
	input  wire spq_ctrl_t          ctrl,
	input  wire                     occupied,   // slot holds a live entry
	input  wire                     at_tail,    // first free slot
	input  wire [DATA_W-1:0]        new_data,
	input  wire [KEY_BITS-1:0]      new_key,
	input  wire                     prev_go,    // left neighbor is shifting right
	input  wire [DATA_W-1:0]        prev_data,
	input  wire [KEY_BITS-1:0]      prev_key,
	input  wire [DATA_W-1:0]        next_data,
	input  wire [KEY_BITS-1:0]      next_key,
	output logic                    go,
	output logic [DATA_W-1:0]       data,
	output logic [KEY_BITS-1:0]     key
);

	logic [DATA_W-1:0]   data_q;
	logic [KEY_BITS-1:0] key_q;
	logic                ins;

	// New key sorts strictly ahead of this entry: this entry moves right
	assign go  = occupied && (key_q > new_key);
	assign ins = go || at_tail;

	// Shift right on insert, left on remove
	always_ff @(posedge clk) begin
		if (ctrl.enq && ins) begin
			if (prev_go) begin
				data_q <= prev_data;
				key_q  <= prev_key;
			end else begin
				data_q <= new_data;
				key_q  <= new_key;
			end
		end else if (ctrl.deq) begin
			data_q <= next_data;
			key_q  <= next_key;
		end
	end

	assign data = data_q;
	assign key  = key_q;

endmodule

`default_nettype wire

[design/sorted_priority_queue.sv]
// Top level of the sorted priority queue: a chain of key/data cells with a fill counter.
//
//  channel   signals                                    beat taken when
//  command   start, busy, op, item_data, item_priority  start && !busy at clk rise
//  result    done, status, out_data, out_priority,      done high for one cycle
//            fill_count
//
// One command per cycle; busy stays low. The result of a command appears
// with done in the cycle after it is taken, set by the single register stage
// behind the cell chain. Every cell compares and shifts in the same cycle.
// arst_n clears the fill count and done; the slot contents are left as is.
// The result side cannot stall; each result beat is shown for one cycle.
`default_nettype none

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire                              op,
	input  wire [DATA_W-1:0]                 item_data,
	input  wire [PRIO_W-1:0]                 item_priority,
	output logic                             done,
	output logic [STATUS_W-1:0]              status,
	output logic [DATA_W-1:0]                out_data,
	output logic [PRIO_W-1:0]                out_priority,
	output logic [$clog2(DEPTH+1)-1:0]       fill_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]         count_q;
	logic                     done_q;
	logic [STATUS_W-1:0]      status_q;
	logic [DATA_W-1:0]        out_data_q;
	logic [PRIO_W-1:0]        out_prio_q;

	logic                     accept;
	logic                     enq_ok;
	logic                     deq_ok;
	spq_ctrl_t                ctrl;
	logic [KEY_BITS+PRIO_W-1:0] key_ext;
	logic [KEY_BITS-1:0]      new_key;
	logic [KEY_BITS+PRIO_W-1:0] head_ext;

	logic [DATA_W-1:0]        cell_data [DEPTH];
	logic [KEY_BITS-1:0]      cell_key  [DEPTH];
	logic                     cell_go   [DEPTH];

	// Command decode
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign enq_ok = accept && (op == OP_ENQ) && (count_q != FULL_CNT);
	assign deq_ok = accept && (op == OP_DEQ) && (count_q != '0);
	assign ctrl.enq = enq_ok;
	assign ctrl.deq = deq_ok;

	// Key kept in its low KEY_BITS bits
	assign key_ext = {{KEY_BITS{1'b0}}, item_priority};
	assign new_key = key_ext[KEY_BITS-1:0];

	// Cell chain, head at cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic                 prev_go;
		logic [DATA_W-1:0]    prev_data;
		logic [KEY_BITS-1:0]  prev_key;
		logic [DATA_W-1:0]    next_data;
		logic [KEY_BITS-1:0]  next_key;

		if (i == 0) begin : g_first
			assign prev_go   = 1'b0;
			assign prev_data = '0;
			assign prev_key  = '0;
		end else begin : g_mid
			assign prev_go   = cell_go[i-1];
			assign prev_data = cell_data[i-1];
			assign prev_key  = cell_key[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_data = '0;
			assign next_key  = '0;
		end else begin : g_inner
			assign next_data = cell_data[i+1];
			assign next_key  = cell_key[i+1];
		end

		spq_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (IDX < count_q),
			.at_tail   (IDX == count_q),
			.new_data  (item_data),
			.new_key   (new_key),
			.prev_go   (prev_go),
			.prev_data (prev_data),
			.prev_key  (prev_key),
			.next_data (next_data),
			.next_key  (next_key),
			.go        (cell_go[i]),
			.data      (cell_data[i]),
			.key       (cell_key[i])
		);
	end

	assign head_ext = {{PRIO_W{1'b0}}, cell_key[0]};

	// Fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (enq_ok) begin
				count_q <= count_q + 1'b1;
			end else if (deq_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (deq_ok) begin
				status_q   <= ST_OK;
				out_data_q <= cell_data[0];
				out_prio_q <= head_ext[PRIO_W-1:0];
			end else begin
				if (op == OP_DEQ) begin
					status_q <= ST_EMPTY;
				end else if (enq_ok) begin
					status_q <= ST_OK;
				end else begin
					status_q <= ST_FULL;
				end
				out_data_q <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;
	assign fill_count   = count_q;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the sorted priority queue: command driver, result checker, tests.
`timescale 1ns / 100ps

module tb_top;
	import spq_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;
	localparam int FILL_W = $clog2(QDEPTH + 1);
	localparam int RANDOM_BEATS = 550;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   data;
		logic [PRIO_W-1:0]   prio;
		logic [FILL_W-1:0]   fill;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = OP_ENQ;
	logic [DATA_W-1:0] item_data = '0;
	logic [PRIO_W-1:0] item_priority = '0;
	logic busy;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0] out_data;
	logic [PRIO_W-1:0] out_priority;
	logic [FILL_W-1:0] fill_count;

	// Shadow copy of the sorted store, head at slot 0
	logic [DATA_W-1:0] shadow_data [QDEPTH];
	logic [PRIO_W-1:0] shadow_key [QDEPTH];
	int shadow_count = 0;

	queue_result_t expected_results[$];
	int mismatches = 0;
	bit idle_on = 1'b1;

	sorted_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.item_data    (item_data),
		.item_priority(item_priority),
		.done         (done),
		.status       (status),
		.out_data     (out_data),
		.out_priority (out_priority),
		.fill_count   (fill_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one command to the shadow store and return the result it must give
	function automatic queue_result_t apply_command(logic cmd_op, logic [DATA_W-1:0] d,
			logic [PRIO_W-1:0] k);
		queue_result_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		if (cmd_op == OP_ENQ) begin
			if (shadow_count >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				// new entry goes behind every entry with key <= its own
				pos = 0;
				while (pos < shadow_count && shadow_key[pos] <= k)
					pos++;
				for (int i = shadow_count; i > pos; i--) begin
					shadow_data[i] = shadow_data[i-1];
					shadow_key[i]  = shadow_key[i-1];
				end
				shadow_data[pos] = d;
				shadow_key[pos]  = k;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.data = shadow_data[0];
				r.prio = shadow_key[0];
				for (int i = 0; i + 1 < shadow_count; i++) begin
					shadow_data[i] = shadow_data[i+1];
					shadow_key[i]  = shadow_key[i+1];
				end
				shadow_count--;
			end
		end
		r.fill = FILL_W'(shadow_count);
		return r;
	endfunction

	function automatic int draw_gap();
		return idle_on ? int'($urandom_range(0, 19)) : 0;
	endfunction

	// Send one command beat; start stays high afterwards so back-to-back beats are seamless
	task automatic send_command(input logic cmd_op, input logic [DATA_W-1:0] d,
			input logic [PRIO_W-1:0] k);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		op            <= cmd_op;
		item_data     <= d;
		item_priority <= k;
		do @(posedge clk); while (busy);
		expected_results.push_back(apply_command(cmd_op, d, k));
	endtask

	// Result checker: every done beat is matched against the oldest expectation
	always @(posedge clk) begin
		queue_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result beat status=%0d data=%02h prio=%02h fill=%0d",
						$realtime, status, out_data, out_priority, fill_count);
			end else begin
				exp_r = expected_results.pop_front();
				if (status !== exp_r.status || out_data !== exp_r.data ||
						out_priority !== exp_r.prio || fill_count !== exp_r.fill) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: mismatch exp status=%0d data=%02h prio=%02h fill=%0d, got status=%0d data=%02h prio=%02h fill=%0d",
							$realtime, exp_r.status, exp_r.data, exp_r.prio, exp_r.fill,
							status, out_data, out_priority, fill_count);
				end
			end
		end
	end

	// Dequeue from the empty queue as the first command after reset
	task automatic test_empty_dequeue();
		send_command(OP_DEQ, 8'($urandom), 8'($urandom));
	endtask

	// Extreme keys and data, ties on one key leave in arrival order
	task automatic test_key_order();
		idle_on = 1'b0;
		send_command(OP_ENQ, 8'hFF, 8'hFF);
		send_command(OP_ENQ, 8'h00, 8'h00);
		send_command(OP_ENQ, 8'h5A, 8'h80);
		send_command(OP_ENQ, 8'hA5, 8'h80);
		send_command(OP_ENQ, 8'h3C, 8'h80);
		idle_on = 1'b1;
		repeat (5) send_command(OP_DEQ, 8'($urandom), 8'($urandom));
	endtask

	// Fill to capacity, then enqueue must be refused
	task automatic test_full_refusal();
		while (shadow_count < QDEPTH)
			send_command(OP_ENQ, 8'($urandom), 8'($urandom));
		send_command(OP_ENQ, 8'hFF, 8'h00);
		send_command(OP_ENQ, 8'h00, 8'hFF);
	endtask

	// Phases biased to fill or drain, or balanced, so full and empty are hit over and over
	task automatic test_random_mix();
		int beats_left;
		int phase_len;
		int enq_pct;
		bit narrow_keys;
		logic [PRIO_W-1:0] k;
		beats_left = RANDOM_BEATS;
		while (beats_left > 0) begin
			phase_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			narrow_keys = ($urandom_range(0, 2) == 0);
			idle_on = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < phase_len && beats_left > 0; n++) begin
				k = narrow_keys ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
				if ($urandom_range(0, 99) < enq_pct)
					send_command(OP_ENQ, 8'($urandom), k);
				else
					send_command(OP_DEQ, 8'($urandom), k);
				beats_left--;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_dequeue();
		test_key_order();
		test_full_refusal();
		test_random_mix();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/sv/tb_top.sv
